### src/fcrr_pkg.sv
`default_nettype none
package fcrr_pkg;

   localparam int MAX_RUN_SECTORS_DEF = 128;
   localparam logic [27:0] CHAIN_END   = 28'hFFF_FFF8;
   localparam logic [7:0]  SPC_MAX     = 8'd128;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_WAIT_FAT,
      PH_WAIT_READ
   } phase_type;

   // request codes
   localparam logic [1:0] REQ_START = 2'd0;
   localparam logic [1:0] REQ_FAT   = 2'd1;
   localparam logic [1:0] REQ_READ  = 2'd2;

   // result codes
   localparam logic [1:0] KIND_LOOKUP = 2'd0;
   localparam logic [1:0] KIND_READ   = 2'd1;
   localparam logic [1:0] KIND_DONE   = 2'd2;

   // register indexes
   localparam logic [1:0] CSR_FAT_START  = 2'd0;
   localparam logic [1:0] CSR_DATA_START = 2'd1;
   localparam logic [1:0] CSR_SPC        = 2'd2;

   typedef struct packed {
      logic [31:0] fat_start_lba;
      logic [31:0] data_start_lba;
      logic [7:0]  sectors_per_cluster;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [27:0] start_cluster;
      logic [31:0] dest_address;
      logic [31:0] max_bytes;
      logic [31:0] fat_entry;
      logic        read_ok;
   } req_item_type;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [31:0] block_lba;
      logic [6:0]  fat_slot;
      logic [7:0]  sector_count;
      logic [31:0] target_address;
      logic [32:0] total_bytes;
   } rsp_item_type;

   typedef struct packed {
      phase_type   phase;
      logic [27:0] current_cluster;
      logic [27:0] run_first_cluster;
      logic [7:0]  run_count;
      logic [32:0] bytes_done;
      logic [31:0] byte_limit;
      logic [31:0] dest_base;
      logic [27:0] following_cluster;
      logic [7:0]  pending_sectors;
   } walk_state_type;

endpackage
`default_nettype wire

### src/fcrr_step.sv
`default_nettype none
module fcrr_step import fcrr_pkg::*; #(
   parameter int MAX_RUN_SECTORS = MAX_RUN_SECTORS_DEF
) (
   input  wire cfg_type        cfg,
   input  wire walk_state_type state_cur,
   input  wire req_item_type   item,
   output walk_state_type      state_nxt,
   output rsp_item_type        result,
   output logic                has_result
);

   logic [7:0]  spc;
   logic [27:0] nxt_cl;
   logic [8:0]  more;
   logic [16:0] more_sec;
   logic [33:0] ext_total;
   logic        extend;
   logic [15:0] full_sec;
   logic [33:0] full_total;
   logic [33:0] left_bytes;
   logic [15:0] read_sec;
   logic [27:0] run_off;
   logic [35:0] run_prod;
   logic [31:0] read_lba;
   logic [32:0] done_new;
   logic        go_on;

   always_comb begin
      if (cfg.sectors_per_cluster == 8'd0) begin
         spc = 8'd1;
      end else if (cfg.sectors_per_cluster > SPC_MAX) begin
         spc = SPC_MAX;
      end else begin
         spc = cfg.sectors_per_cluster;
      end
   end

   // run extension test
   assign nxt_cl    = item.fat_entry[27:0];
   assign more      = {1'b0, state_cur.run_count} + 9'd1;
   assign more_sec  = 17'(more) * 17'(spc);
   assign ext_total = {1'b0, state_cur.bytes_done} + {8'd0, more_sec, 9'd0};
   assign extend    = ({1'b0, nxt_cl} == {1'b0, state_cur.current_cluster} + 29'd1)
                   && (more_sec <= 17'(MAX_RUN_SECTORS))
                   && (ext_total <= {2'b00, state_cur.byte_limit});

   // read command, trimmed to the whole sectors that cover the limit
   assign full_sec   = 16'(state_cur.run_count) * 16'(spc);
   assign full_total = {1'b0, state_cur.bytes_done} + {9'd0, full_sec, 9'd0};
   assign left_bytes = {2'b00, state_cur.byte_limit} - {1'b0, state_cur.bytes_done} + 34'd511;
   assign read_sec   = (full_total > {2'b00, state_cur.byte_limit}) ?
                       left_bytes[24:9] : full_sec;
   assign run_off    = state_cur.run_first_cluster - 28'd2;
   assign run_prod   = 36'(run_off) * 36'(spc);
   assign read_lba   = cfg.data_start_lba + run_prod[31:0];

   // read status
   assign done_new = state_cur.bytes_done + {16'd0, state_cur.pending_sectors, 9'd0};
   assign go_on    = (state_cur.following_cluster >= 28'd2)
                  && (state_cur.following_cluster < CHAIN_END)
                  && (done_new < {1'b0, state_cur.byte_limit});

   always_comb begin
      state_nxt  = state_cur;
      result     = '0;
      has_result = 1'b0;
      case (item.req_type)
         REQ_START: begin
            has_result                  = 1'b1;
            state_nxt.dest_base         = item.dest_address;
            state_nxt.byte_limit        = item.max_bytes;
            state_nxt.bytes_done        = '0;
            state_nxt.pending_sectors   = '0;
            state_nxt.following_cluster = '0;
            state_nxt.run_count         = '0;
            if (item.start_cluster < 28'd2 || item.start_cluster >= CHAIN_END
                || item.max_bytes == 32'd0) begin
               state_nxt.phase    = PH_IDLE;
               result.result_kind = KIND_DONE;
            end else begin
               state_nxt.phase             = PH_WAIT_FAT;
               state_nxt.run_first_cluster = item.start_cluster;
               state_nxt.current_cluster   = item.start_cluster;
               state_nxt.run_count         = 8'd1;
               result.result_kind = KIND_LOOKUP;
               result.block_lba   = cfg.fat_start_lba + {11'd0, item.start_cluster[27:7]};
               result.fat_slot    = item.start_cluster[6:0];
            end
         end
         REQ_FAT: begin
            if (state_cur.phase == PH_WAIT_FAT) begin
               has_result         = 1'b1;
               result.total_bytes = state_cur.bytes_done;
               if (extend) begin
                  state_nxt.run_count       = more[7:0];
                  state_nxt.current_cluster = nxt_cl;
                  result.result_kind = KIND_LOOKUP;
                  result.block_lba   = cfg.fat_start_lba + {11'd0, nxt_cl[27:7]};
                  result.fat_slot    = nxt_cl[6:0];
               end else begin
                  state_nxt.following_cluster = nxt_cl;
                  state_nxt.pending_sectors   = read_sec[7:0];
                  state_nxt.phase             = PH_WAIT_READ;
                  result.result_kind    = KIND_READ;
                  result.block_lba      = read_lba;
                  result.sector_count   = read_sec[7:0];
                  result.target_address = state_cur.dest_base + state_cur.bytes_done[31:0];
               end
            end
         end
         REQ_READ: begin
            if (state_cur.phase == PH_WAIT_READ) begin
               has_result = 1'b1;
               if (!item.read_ok) begin
                  state_nxt.phase    = PH_IDLE;
                  result.result_kind = KIND_DONE;
                  result.total_bytes = state_cur.bytes_done;
               end else begin
                  state_nxt.bytes_done      = done_new;
                  state_nxt.pending_sectors = '0;
                  state_nxt.current_cluster = state_cur.following_cluster;
                  result.total_bytes        = done_new;
                  if (go_on) begin
                     state_nxt.phase             = PH_WAIT_FAT;
                     state_nxt.run_first_cluster = state_cur.following_cluster;
                     state_nxt.run_count         = 8'd1;
                     result.result_kind = KIND_LOOKUP;
                     result.block_lba   = cfg.fat_start_lba
                                        + {11'd0, state_cur.following_cluster[27:7]};
                     result.fat_slot    = state_cur.following_cluster[6:0];
                  end else begin
                     state_nxt.phase    = PH_IDLE;
                     result.result_kind = KIND_DONE;
                  end
               end
            end
         end
         default: begin
            has_result = 1'b0;
         end
      endcase
   end

endmodule
`default_nettype wire

### src/fat32_cluster_run_reader_top.sv
// Channel   Handshake            Direction  Carries
// req_      req_valid/req_stall  in         start, FAT entry or read status request
// rsp_      rsp_valid/rsp_stall  out        FAT lookup, read command or done
// csr_      csr_valid/csr_ready  in         register index and write data
//
// One request every cycle while req_stall is low; a result, if the request gives one,
// goes from the input register through one pass of the step logic into the result register and onto rsp_.
// The longest path is the 28x8 cluster-to-sector multiply plus the LBA add.
// Synchronous active-high reset clears the walk state and sets the registers to
// their defaults. rsp_stall holds the result register; the input register then
// fills and req_stall rises. csr_ready is always high.
`default_nettype none
module fat32_cluster_run_reader_top import fcrr_pkg::*; #(
   parameter int MAX_RUN_SECTORS = MAX_RUN_SECTORS_DEF
) (
   input  wire         clock,
   input  wire         reset,

   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [1:0]  req_type,
   input  wire  [27:0] req_start_cluster,
   input  wire  [31:0] req_dest_address,
   input  wire  [31:0] req_max_bytes,
   input  wire  [31:0] req_fat_entry,
   input  wire         req_read_ok,

   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic [1:0]  rsp_result_kind,
   output logic [31:0] rsp_block_lba,
   output logic [6:0]  rsp_fat_slot,
   output logic [7:0]  rsp_sector_count,
   output logic [31:0] rsp_target_address,
   output logic [32:0] rsp_total_bytes,

   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [1:0]  csr_index,
   input  wire  [31:0] csr_data
);

   cfg_type        cfg_ff;
   logic           in_valid_ff;
   req_item_type   in_item_ff;
   walk_state_type state_ff;
   walk_state_type state_in;
   rsp_item_type   step_rsp;
   logic           step_has;
   rsp_item_type   rsp_ff;
   logic           rsp_valid_ff;
   logic           out_free;
   logic           fire;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{fat_start_lba: 32'd0, data_start_lba: 32'd0,
                     sectors_per_cluster: 8'd1};
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_FAT_START:  cfg_ff.fat_start_lba       <= csr_data;
            CSR_DATA_START: cfg_ff.data_start_lba      <= csr_data;
            CSR_SPC:        cfg_ff.sectors_per_cluster <= csr_data[7:0];
            default:        ;
         endcase
      end
   end

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_item_ff <= '{req_type, req_start_cluster, req_dest_address,
                         req_max_bytes, req_fat_entry, req_read_ok};
      end
   end

   fcrr_step #(
      .MAX_RUN_SECTORS(MAX_RUN_SECTORS)
   ) u_step (
      .cfg        (cfg_ff),
      .state_cur  (state_ff),
      .item       (in_item_ff),
      .state_nxt  (state_in),
      .result     (step_rsp),
      .has_result (step_has)
   );

   // all-zero state is idle
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (fire) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire && step_has) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && step_has) begin
         rsp_ff <= step_rsp;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_kind    = rsp_ff.result_kind;
   assign rsp_block_lba      = rsp_ff.block_lba;
   assign rsp_fat_slot       = rsp_ff.fat_slot;
   assign rsp_sector_count   = rsp_ff.sector_count;
   assign rsp_target_address = rsp_ff.target_address;
   assign rsp_total_bytes    = rsp_ff.total_bytes;

`ifndef NO_ASSERTIONS
   a_read_waits: assert property (@(posedge clock) disable iff (reset)
      fire && step_has && step_rsp.result_kind == KIND_READ
      |=> state_ff.phase == PH_WAIT_READ)
      else $error("read command issued without waiting for its status");

   a_done_idles: assert property (@(posedge clock) disable iff (reset)
      fire && step_has && step_rsp.result_kind == KIND_DONE
      |=> state_ff.phase == PH_IDLE)
      else $error("walk not idle after done");

   a_bytes_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff.bytes_done <= {1'b0, state_ff.byte_limit} + 33'd511)
      else $error("byte count beyond limit rounded to a sector");
`endif

endmodule
`default_nettype wire

### bench/testbench.sv
`timescale 1ns / 1ps
module testbench;
   import fcrr_pkg::*;

   localparam logic [1:0]  REQ_UNUSED  = 2'd3;
   localparam logic [1:0]  CSR_SPARE   = 2'd3;
   localparam logic [27:0] END_MARK    = 28'hFFF_FFF8;
   localparam int          STALL_LIMIT = 2000;

   // Mirrors the chain walk: register copies, walk state and the responses still due.
   class chain_walk_scoreboard;
      logic [31:0]  fat_lba;
      logic [31:0]  data_lba;
      logic [7:0]   spc_reg;
      phase_type    ph;
      logic [27:0]  cur_cl;
      logic [27:0]  run_first;
      logic [27:0]  next_cl;
      logic [7:0]   run_len;
      logic [32:0]  done_bytes;
      logic [31:0]  limit;
      logic [31:0]  base;
      logic [16:0]  held_bytes;
      rsp_item_type due_responses[$];
      int           errors;

      function new();
         fat_lba    = '0;
         data_lba   = '0;
         spc_reg    = 8'd1;
         ph         = PH_IDLE;
         cur_cl     = '0;
         run_first  = '0;
         next_cl    = '0;
         run_len    = '0;
         done_bytes = '0;
         limit      = '0;
         base       = '0;
         held_bytes = '0;
         errors     = 0;
      endfunction

      function void set_reg(logic [1:0] idx, logic [31:0] val);
         case (idx)
            CSR_FAT_START:  fat_lba  = val;
            CSR_DATA_START: data_lba = val;
            CSR_SPC:        spc_reg  = val[7:0];
            default: ;
         endcase
      endfunction

      // zero behaves as one sector, anything over 128 as 128
      function longint unsigned eff_spc();
         if (spc_reg == 8'd0) return 1;
         if (spc_reg > 8'd128) return 128;
         return spc_reg;
      endfunction

      function rsp_item_type walk_done();
         rsp_item_type e;
         e = '0;
         ph = PH_IDLE;
         e.result_kind = KIND_DONE;
         e.total_bytes = done_bytes;
         return e;
      endfunction

      function rsp_item_type lookup(logic [27:0] cl);
         rsp_item_type e;
         e = '0;
         e.result_kind = KIND_LOOKUP;
         e.block_lba   = fat_lba + {11'b0, cl[27:7]};
         e.fat_slot    = cl[6:0];
         e.total_bytes = done_bytes;
         return e;
      endfunction

      function rsp_item_type start_run(logic [27:0] cl);
         run_first = cl;
         cur_cl    = cl;
         run_len   = 8'd1;
         ph        = PH_WAIT_FAT;
         return lookup(cl);
      endfunction

      function void note_request(req_item_type r);
         rsp_item_type    e;
         logic [27:0]     nxt;
         longint unsigned spc;
         longint unsigned more;
         longint unsigned sectors;
         longint unsigned nbytes;
         longint unsigned lba64;
         case (r.req_type)
            REQ_START: begin
               base       = r.dest_address;
               limit      = r.max_bytes;
               done_bytes = '0;
               held_bytes = '0;
               next_cl    = '0;
               run_len    = '0;
               if (r.start_cluster < 28'd2 || r.start_cluster >= END_MARK ||
                   r.max_bytes == 32'd0)
                  due_responses.push_back(walk_done());
               else
                  due_responses.push_back(start_run(r.start_cluster));
            end
            REQ_FAT: if (ph == PH_WAIT_FAT) begin
               nxt  = r.fat_entry[27:0];
               spc  = eff_spc();
               more = run_len + 64'd1;
               if (longint'(nxt) == longint'(cur_cl) + 1 && more * spc <= 128 &&
                   done_bytes + more * spc * 512 <= limit) begin
                  run_len = more[7:0];
                  cur_cl  = nxt;
                  due_responses.push_back(lookup(nxt));
               end else begin
                  next_cl = nxt;
                  sectors = run_len * spc;
                  nbytes  = sectors * 512;
                  // trim to whole sectors covering what is left of the limit
                  if (done_bytes + nbytes > limit) begin
                     sectors = (limit - done_bytes + 511) / 512;
                     nbytes  = sectors * 512;
                  end
                  held_bytes = nbytes[16:0];
                  ph    = PH_WAIT_READ;
                  lba64 = data_lba + (run_first - 28'd2) * spc;
                  e = '0;
                  e.result_kind    = KIND_READ;
                  e.block_lba      = lba64[31:0];
                  e.sector_count   = sectors[7:0];
                  e.target_address = base + done_bytes[31:0];
                  e.total_bytes    = done_bytes;
                  due_responses.push_back(e);
               end
            end
            REQ_READ: if (ph == PH_WAIT_READ) begin
               if (!r.read_ok) begin
                  due_responses.push_back(walk_done());
               end else begin
                  done_bytes = done_bytes + held_bytes;
                  held_bytes = '0;
                  cur_cl     = next_cl;
                  if (cur_cl >= 28'd2 && cur_cl < END_MARK && done_bytes < limit)
                     due_responses.push_back(start_run(cur_cl));
                  else
                     due_responses.push_back(walk_done());
               end
            end
            default: ;
         endcase
      endfunction

      task report(string msg);
         errors++;
         $display("%t mismatch: %s", $time, msg);
      endtask

      task compare_field(string name, logic [32:0] got, logic [32:0] want);
         if (got !== want) report($sformatf("%s got %h, expected %h", name, got, want));
      endtask

      task check_response(rsp_item_type got);
         rsp_item_type want;
         if (due_responses.size() == 0) begin
            report($sformatf("response kind %0d with nothing due", got.result_kind));
            return;
         end
         want = due_responses.pop_front();
         compare_field("result_kind", got.result_kind, want.result_kind);
         compare_field("block_lba", got.block_lba, want.block_lba);
         compare_field("fat_slot", got.fat_slot, want.fat_slot);
         compare_field("sector_count", got.sector_count, want.sector_count);
         compare_field("target_address", got.target_address, want.target_address);
         compare_field("total_bytes", got.total_bytes, want.total_bytes);
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_type = '0;
   logic [27:0] req_start_cluster = '0;
   logic [31:0] req_dest_address = '0;
   logic [31:0] req_max_bytes = '0;
   logic [31:0] req_fat_entry = '0;
   logic        req_read_ok = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_result_kind;
   logic [31:0] rsp_block_lba;
   logic [6:0]  rsp_fat_slot;
   logic [7:0]  rsp_sector_count;
   logic [31:0] rsp_target_address;
   logic [32:0] rsp_total_bytes;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [31:0] csr_data = '0;
   bit          calm = 1'b0;

   chain_walk_scoreboard walk = new();

   fat32_cluster_run_reader_top i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_type           (req_type),
      .req_start_cluster  (req_start_cluster),
      .req_dest_address   (req_dest_address),
      .req_max_bytes      (req_max_bytes),
      .req_fat_entry      (req_fat_entry),
      .req_read_ok        (req_read_ok),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_result_kind    (rsp_result_kind),
      .rsp_block_lba      (rsp_block_lba),
      .rsp_fat_slot       (rsp_fat_slot),
      .rsp_sector_count   (rsp_sector_count),
      .rsp_target_address (rsp_target_address),
      .rsp_total_bytes    (rsp_total_bytes),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_item_type got;
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         got.result_kind    = rsp_result_kind;
         got.block_lba      = rsp_block_lba;
         got.fat_slot       = rsp_fat_slot;
         got.sector_count   = rsp_sector_count;
         got.target_address = rsp_target_address;
         got.total_bytes    = rsp_total_bytes;
         walk.check_response(got);
      end
      rsp_stall <= !calm && ($urandom_range(99) < 33);
   end

   function automatic req_item_type mk(logic [1:0] code, logic [27:0] cl, logic [31:0] dest,
                                       logic [31:0] lim, logic [31:0] entry, logic ok);
      req_item_type r;
      r.req_type      = code;
      r.start_cluster = cl;
      r.dest_address  = dest;
      r.max_bytes     = lim;
      r.fat_entry     = entry;
      r.read_ok       = ok;
      return r;
   endfunction

   // Mostly well-formed follow-ups to the current walk, with some noise and restarts.
   function automatic req_item_type pick_request();
      req_item_type r;
      int unsigned  dice;
      r = mk(REQ_START, 28'($urandom), $urandom, $urandom, $urandom,
             1'($urandom_range(1)));
      dice = $urandom_range(99);
      if (dice < 6) begin
         r.req_type = 2'($urandom_range(3));
         return r;
      end
      if (dice < 9 || walk.ph == PH_IDLE) begin
         dice = $urandom_range(99);
         if (dice < 5)       r.start_cluster = 28'($urandom_range(1));
         else if (dice < 9)  r.start_cluster = END_MARK + 28'($urandom_range(7));
         else if (dice < 60) r.start_cluster = 28'($urandom_range(5000, 2));
         dice = $urandom_range(99);
         if (dice < 4)       r.max_bytes = '0;
         else if (dice < 70) r.max_bytes = $urandom_range(300000, 1);
         return r;
      end
      if (walk.ph == PH_WAIT_FAT) begin
         r.req_type = REQ_FAT;
         dice = $urandom_range(99);
         // upper nibble stays random; the block must mask it off
         if (dice < 80)      r.fat_entry[27:0] = walk.cur_cl + 28'd1;
         else if (dice < 88) r.fat_entry[27:0] = END_MARK + 28'($urandom_range(7));
         else if (dice < 91) r.fat_entry[27:0] = 28'($urandom_range(1));
         else if (dice < 96) r.fat_entry[27:0] = 28'($urandom_range(5000, 2));
         return r;
      end
      r.req_type = REQ_READ;
      r.read_ok  = ($urandom_range(99) < 92);
      return r;
   endfunction

   task automatic send_request(req_item_type r);
      req_valid         <= 1'b1;
      req_type          <= r.req_type;
      req_start_cluster <= r.start_cluster;
      req_dest_address  <= r.dest_address;
      req_max_bytes     <= r.max_bytes;
      req_fat_entry     <= r.fat_entry;
      req_read_ok       <= r.read_ok;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      walk.note_request(r);
   endtask

   task automatic pause_sender();
      while (!calm && $urandom_range(99) < 33) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic send_next(req_item_type r);
      pause_sender();
      send_request(r);
   endtask

   // idle the request side and let every due response and any ignored request clear
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (walk.due_responses.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic program_regs(logic [31:0] fat, logic [31:0] data, logic [7:0] spc);
      logic [1:0]  idx [4];
      logic [31:0] val [4];
      idx = '{CSR_FAT_START, CSR_DATA_START, CSR_SPC, CSR_SPARE};
      val = '{fat, data, ($urandom & 32'hFFFF_FF00) | {24'b0, spc}, $urandom};
      for (int i = 0; i < 4; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[i];
         csr_data  <= val[i];
         @(posedge clock);
         while (csr_ready !== 1'b1) @(posedge clock);
         walk.set_reg(idx[i], val[i]);
      end
      csr_valid <= 1'b0;
   endtask

   task automatic run_directed();
      // empty starts: low clusters, end marker, zero limit
      send_next(mk(REQ_START, 28'd0, 32'h1234_5678, 32'd100, '0, 1'b0));
      send_next(mk(REQ_START, 28'd1, '0, 32'd100, '0, 1'b0));
      send_next(mk(REQ_START, END_MARK, '0, 32'd100, '0, 1'b0));
      send_next(mk(REQ_START, 28'h0FFF_FFFF, '1, '1, '1, 1'b1));
      send_next(mk(REQ_START, 28'd5, '0, '0, '0, 1'b1));
      // out of phase and unknown requests are dropped
      send_next(mk(REQ_FAT, '0, '0, '0, 32'd3, 1'b1));
      send_next(mk(REQ_READ, '0, '0, '0, '0, 1'b1));
      send_next(mk(REQ_UNUSED, '1, '1, '1, '1, 1'b1));
      // top valid cluster, all-ones address and limit
      send_next(mk(REQ_START, 28'hFFF_FFF7, '1, '1, '0, 1'b0));
      send_next(mk(REQ_READ, '0, '0, '0, '0, 1'b1));
      send_next(mk(REQ_FAT, '0, '0, '0, 32'hFFFF_FFF8, 1'b0));
      send_next(mk(REQ_FAT, '0, '0, '0, 32'hF000_0000, 1'b0));
      send_next(mk(REQ_FAT, '0, '0, '0, 32'd7, 1'b0));
      send_next(mk(REQ_READ, '0, '0, '0, '0, 1'b1));
      // small limit: a full read, then a trimmed one that fails
      send_next(mk(REQ_START, 28'd2, '0, 32'd1000, '0, 1'b0));
      send_next(mk(REQ_FAT, '0, '0, '0, 32'd3, 1'b0));
      send_next(mk(REQ_READ, '0, '0, '0, '0, 1'b1));
      send_next(mk(REQ_FAT, '0, '0, '0, 32'h0FFF_FFFF, 1'b0));
      send_next(mk(REQ_READ, '0, '0, '0, '0, 1'b0));
      // restart in the middle of a walk
      send_next(mk(REQ_START, 28'd100, 32'h8000_0000, 32'h0001_0000, '0, 1'b0));
      send_next(mk(REQ_FAT, '0, '0, '0, 32'd101, 1'b0));
      send_next(mk(REQ_START, 28'h0AB_CDEF, 32'hFFFF_FE00, 32'd1, '0, 1'b0));
      send_next(mk(REQ_FAT, '0, '0, '0, 32'h00AB_CDF0, 1'b0));
      send_next(mk(REQ_READ, '0, '0, '0, '0, 1'b1));
   endtask

   initial begin
      int unsigned quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("fat32_cluster_run_reader_top regression: fail");
      $finish;
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      for (int p = 0; p < 6; p++) begin
         case (p)
            0: program_regs(32'h0000_0800, 32'h0000_4000, 8'd1);
            1: program_regs('1, '1, 8'd128);
            2: program_regs('0, '0, 8'd0);
            3: program_regs($urandom, $urandom, 8'd200);
            4: program_regs($urandom, $urandom, 8'($urandom_range(64, 2)));
            default: program_regs($urandom, $urandom, 8'd8);
         endcase
         // one phase runs with neither side idling
         calm = (p == 2);
         if (p == 0) run_directed();
         repeat (145) send_next(pick_request());
         drain();
      end
      if (walk.due_responses.size() != 0)
         walk.report($sformatf("%0d responses never arrived", walk.due_responses.size()));
      if (walk.errors == 0)
         $display("fat32_cluster_run_reader_top regression: pass");
      else
         $display("fat32_cluster_run_reader_top regression: fail");
      $finish;
   end

endmodule
